[design/sfr_pkg.sv]
// Package for the stream find-and-replace block.
// Holds sizes, register indexes, shared types and the length clamp function.
// No dependencies.
package sfr_pkg;

   localparam int MAX_STRING_BYTES = 16;
   localparam int WIN_DEPTH = (MAX_STRING_BYTES < 16) ? MAX_STRING_BYTES : 16;
   localparam int LEN_W = 5;
   localparam int REG_W = 64;
   localparam int ADDR_W = 3;

   localparam logic [ADDR_W-1:0] REG_PATTERN_LO = 3'd0;
   localparam logic [ADDR_W-1:0] REG_PATTERN_HI = 3'd1;
   localparam logic [ADDR_W-1:0] REG_PATTERN_LEN = 3'd2;
   localparam logic [ADDR_W-1:0] REG_REPL_LO = 3'd3;
   localparam logic [ADDR_W-1:0] REG_REPL_HI = 3'd4;
   localparam logic [ADDR_W-1:0] REG_REPL_LEN = 3'd5;

   typedef logic [WIN_DEPTH-1:0][7:0] byte_vec_type;

   typedef struct packed {
      byte_vec_type     pattern;
      logic [LEN_W-1:0] pattern_len;
      byte_vec_type     repl;
      logic [LEN_W-1:0] repl_len;
   } cfg_type;

   typedef struct packed {
      byte_vec_type     bytes;
      logic [LEN_W-1:0] count;
      logic             last;
   } burst_type;

   // 0 acts as 1, anything above the window depth acts as the depth
   function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
      logic [LEN_W-1:0] r;
      if (v == '0) begin
         r = LEN_W'(1);
      end else if (v > LEN_W'(WIN_DEPTH)) begin
         r = LEN_W'(WIN_DEPTH);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

[design/sfr_csr.sv]
// Configuration registers of the stream find-and-replace block.
// Depends on sfr_pkg; presents clamped lengths and byte vectors.
module sfr_csr
   import sfr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [ADDR_W-1:0] csr_addr,
   input  logic [REG_W-1:0]  csr_wdata,
   output cfg_type           cfg
);

   logic [REG_W-1:0] pat_lo_ff, pat_hi_ff, repl_lo_ff, repl_hi_ff;
   logic [LEN_W-1:0] pat_len_ff, repl_len_ff;
   logic [2*REG_W-1:0] pat_all, repl_all;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_lo_ff   <= '0;
         pat_hi_ff   <= '0;
         pat_len_ff  <= LEN_W'(1);
         repl_lo_ff  <= '0;
         repl_hi_ff  <= '0;
         repl_len_ff <= LEN_W'(1);
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_PATTERN_LO:  pat_lo_ff   <= csr_wdata;
            REG_PATTERN_HI:  pat_hi_ff   <= csr_wdata;
            REG_PATTERN_LEN: pat_len_ff  <= csr_wdata[LEN_W-1:0];
            REG_REPL_LO:     repl_lo_ff  <= csr_wdata;
            REG_REPL_HI:     repl_hi_ff  <= csr_wdata;
            REG_REPL_LEN:    repl_len_ff <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign pat_all  = {pat_hi_ff, pat_lo_ff};
   assign repl_all = {repl_hi_ff, repl_lo_ff};

   always_comb begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
         cfg.pattern[i] = pat_all[8*i +: 8];
         cfg.repl[i]    = repl_all[8*i +: 8];
      end
      cfg.pattern_len = eff_len(pat_len_ff);
      cfg.repl_len    = eff_len(repl_len_ff);
   end

endmodule

[design/sfr_step.sv]
// Sliding match window and per-item compare for stream find-and-replace.
// Depends on sfr_pkg; produces the result burst for each accepted item.
module sfr_step
   import sfr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  logic [7:0] data_byte,
   input  logic      end_of_stream,
   input  cfg_type   cfg,
   output burst_type burst
);

   byte_vec_type     window_ff, window_in;
   logic [LEN_W-1:0] fill_ff, fill_in;

   byte_vec_type     w1, w2;
   logic [LEN_W-1:0] drop, fill1, fill2;
   logic             full, hit;
   logic [WIN_DEPTH-1:0] byte_ok;

   always_comb begin
      // trim excess bytes left by a shortened pattern
      if (fill_ff >= cfg.pattern_len) begin
         drop  = fill_ff - cfg.pattern_len + LEN_W'(1);
         fill1 = cfg.pattern_len - LEN_W'(1);
      end else begin
         drop  = '0;
         fill1 = fill_ff;
      end
      w1 = window_ff >> {drop, 3'b000};

      for (int i = 0; i < WIN_DEPTH; i++) begin
         w2[i] = (LEN_W'(i) == fill1) ? data_byte : w1[i];
         byte_ok[i] = (LEN_W'(i) >= cfg.pattern_len) || (w2[i] == cfg.pattern[i]);
      end
      fill2 = fill1 + LEN_W'(1);
      full  = (fill2 == cfg.pattern_len);
      hit   = full && (&byte_ok);

      burst.last = end_of_stream;
      if (hit) begin
         burst.bytes = cfg.repl;
         burst.count = cfg.repl_len;
      end else begin
         burst.bytes = w2;
         if (end_of_stream) begin
            burst.count = fill2;
         end else begin
            burst.count = full ? LEN_W'(1) : '0;
         end
      end

      window_in = w2;
      fill_in   = fill2;
      if (hit || end_of_stream) begin
         fill_in = '0;
      end else if (full) begin
         window_in = w2 >> 8;
         fill_in   = cfg.pattern_len - LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff <= window_in;
      end
   end

endmodule

[design/sfr_burst.sv]
// Result register of stream find-and-replace: shifts a burst out one byte per item.
// Depends on sfr_pkg; flags the final byte of a burst that ends a stream.
module sfr_burst
   import sfr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  burst_type burst,
   output logic      take_ready,
   output logic      rsp_tvalid,
   input  logic      rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic      rsp_tlast
);

   byte_vec_type     bytes_ff, bytes_in;
   logic [LEN_W-1:0] count_ff, count_in;
   logic             last_ff, last_in;
   logic             pop;

   assign pop        = (count_ff != '0) && rsp_tready;
   assign take_ready = (count_ff == '0) || ((count_ff == LEN_W'(1)) && rsp_tready);

   always_comb begin
      bytes_in = bytes_ff;
      count_in = count_ff;
      last_in  = last_ff;
      if (load) begin
         bytes_in = burst.bytes;
         count_in = burst.count;
         last_in  = burst.last;
      end else if (pop) begin
         bytes_in = bytes_ff >> 8;
         count_in = count_ff - LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         last_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = bytes_ff[0];
   assign rsp_tlast  = last_ff && (count_ff == LEN_W'(1));

endmodule

[design/stream_find_replace.sv]
// Stream find-and-replace: a byte stream in, the stream with every leftmost,
// non-overlapping match of a configured pattern replaced, one byte per item out.
// An item is taken in every cycle as long as each item yields at most one result
// byte and the result side is ready; an item that completes a match yields
// replacement_length bytes and one that ends a stream flushes the window, and either
// holds the input while the single result shift register drains. The first result
// byte of an item appears in the cycle after it is taken. Lengths of 0 act as 1 and
// lengths above 16 act as 16. Configuration must be written only while the block is
// idle; it is not enforced. Depends on sfr_pkg, sfr_csr, sfr_step and sfr_burst.
module stream_find_replace
   import sfr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] data_byte
   input  logic              req_tlast,   // end_of_stream
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // [7:0] out_byte
   output logic              rsp_tlast,   // out_last
   input  logic              csr_we,
   input  logic [ADDR_W-1:0] csr_addr,
   input  logic [REG_W-1:0]  csr_wdata
);

   cfg_type   cfg;
   burst_type burst;
   logic      accept;
   logic      take_ready;

   assign req_tready = take_ready;
   assign accept     = req_tvalid && take_ready;

   sfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sfr_step u_step (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_tdata),
      .end_of_stream (req_tlast),
      .cfg           (cfg),
      .burst         (burst)
   );

   sfr_burst u_burst (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .burst      (burst),
      .take_ready (take_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[design/sfr_checker.sv]
// Port-level checks for stream_find_replace, bound to the top level.
// Depends on the top level's port list only.
module sfr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result item changed");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with no result pending");

   a_last_yields: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> rsp_tvalid)
      else $error("end of stream produced no result");

   a_quiet_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast && !(req_tvalid && req_tready)
      |=> !rsp_tvalid)
      else $error("result after final item of stream");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (.*);

[tb/sv/tb_stream_find_replace.sv]
`timescale 1ns / 100ps
// Testbench for stream_find_replace: directed and random byte streams with random stalls
// on both sides, checked item by item against a window model kept in the bench.
// Depends on sfr_pkg and stream_find_replace.
module tb_stream_find_replace;
   import sfr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } out_item_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata = '0;   // [7:0] data_byte
   logic              req_tlast = 1'b0; // end_of_stream
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [7:0]        rsp_tdata;        // [7:0] out_byte
   logic              rsp_tlast;        // out_last
   logic              csr_we = 1'b0;
   logic [ADDR_W-1:0] csr_addr = '0;
   logic [REG_W-1:0]  csr_wdata = '0;

   // shadow of the block's registers and match window
   byte_vec_type     pat_sh = '0;
   byte_vec_type     rep_sh = '0;
   logic [LEN_W-1:0] plen_sh = LEN_W'(1);
   logic [LEN_W-1:0] rlen_sh = LEN_W'(1);
   logic [7:0]       window_q[$];
   out_item_type     expected_out[$];

   int   fail_count = 0;
   int   items_sent = 0;
   int   cycle_count = 0;
   logic calm = 1'b0;
   int   hold_reqs = 0;
   int   hold_seen = 0;
   int   hold_left = 0;

   stream_find_replace u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("stream_find_replace verification failed");
         $finish;
      end
   end

   // result side: check, then pick the next ready
   always @(posedge clock) begin : rx_side
      out_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_out.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual byte %02h last %b",
                     $time, rsp_tdata, rsp_tlast);
            fail_count++;
         end else begin
            want = expected_out.pop_front();
            if (rsp_tdata !== want.data) begin
               $display("%0t: out_byte expected %02h actual %02h",
                        $time, want.data, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: out_last expected %b actual %b",
                        $time, want.last, rsp_tlast);
               fail_count++;
            end
         end
      end
      if (hold_seen != hold_reqs) begin
         hold_seen = hold_reqs;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 6);
      end
   end

   function automatic int span(input logic [LEN_W-1:0] v);
      if (v == 0) return 1;
      if (v > WIN_DEPTH) return WIN_DEPTH;
      return int'(v);
   endfunction

   function automatic void predict_replace(input logic [7:0] d, input logic end_flag);
      int           plen;
      int           rlen;
      int           n;
      logic         hit;
      out_item_type t;
      plen = span(plen_sh);
      rlen = span(rlen_sh);
      n = 0;
      while (window_q.size() >= plen) void'(window_q.pop_front());
      window_q.push_back(d);
      if (window_q.size() == plen) begin
         hit = 1'b1;
         for (int i = 0; i < plen; i++) begin
            if (window_q[i] != pat_sh[i]) hit = 1'b0;
         end
         if (hit) begin
            for (int i = 0; i < rlen; i++) expected_out.push_back('{rep_sh[i], 1'b0});
            n += rlen;
            window_q.delete();
         end else begin
            expected_out.push_back('{window_q.pop_front(), 1'b0});
            n++;
         end
      end
      if (end_flag) begin
         foreach (window_q[i]) begin
            expected_out.push_back('{window_q[i], 1'b0});
            n++;
         end
         window_q.delete();
         if (n > 0) begin
            t = expected_out.pop_back();
            t.last = 1'b1;
            expected_out.push_back(t);
         end
      end
   endfunction

   function automatic logic [7:0] pick_sym();
      logic [7:0] v;
      case ($urandom_range(3))
         0: v = 8'h00;
         1: v = 8'hFF;
         2: v = 8'h5A;
         default: v = 8'hA5;
      endcase
      return v;
   endfunction

   task automatic load_regs(input logic [63:0] plo, input logic [63:0] phi,
                            input logic [LEN_W-1:0] plen, input logic [63:0] rlo,
                            input logic [63:0] rhi, input logic [LEN_W-1:0] rlen);
      logic [63:0]       vals[6];
      logic [ADDR_W-1:0] addrs[6];
      vals = '{plo, phi, {$urandom, 27'($urandom), plen},
               rlo, rhi, {$urandom, 27'($urandom), rlen}};
      addrs = '{REG_PATTERN_LO, REG_PATTERN_HI, REG_PATTERN_LEN,
                REG_REPL_LO, REG_REPL_HI, REG_REPL_LEN};
      for (int i = 0; i < 6; i++) begin
         csr_we <= 1'b1;
         csr_addr <= addrs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      pat_sh = {phi, plo};
      rep_sh = {rhi, rlo};
      plen_sh = plen;
      rlen_sh = rlen;
   endtask

   task automatic send_item(input logic [7:0] d, input logic end_flag);
      while (!calm && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tlast <= end_flag;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_replace(d, end_flag);
      items_sent++;
   endtask

   task automatic send_stream(input logic [7:0] s[$], input logic closed);
      foreach (s[i]) send_item(s[i], closed && (i == s.size() - 1));
   endtask

   // no item may be in flight when registers change
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_out.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_reset_defaults();
      send_stream('{8'h00, 8'hFF}, 1'b1);
      wait_idle();
   endtask

   // length 0 acts as 1, 31 acts as 16
   task automatic test_length_clamps();
      load_regs(64'h0000_0000_0000_00FF, 64'h0, 5'd0,
                64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908, 5'd31);
      send_stream('{8'hFF, 8'h00}, 1'b1);
      wait_idle();
   endtask

   task automatic test_leftmost_no_overlap();
      load_regs(64'h6161, 64'h0, 5'd2, 64'h5A, 64'h0, 5'd1);
      send_stream('{8'h61, 8'h61, 8'h61, 8'h61, 8'h61}, 1'b1);
      wait_idle();
   endtask

   task automatic test_pattern_shrunk_mid_stream();
      load_regs(64'h6463_6261, 64'h0, 5'd4, 64'h3231, 64'h0, 5'd2);
      send_stream('{8'h78, 8'h79, 8'h61}, 1'b0);
      wait_idle();
      load_regs(64'h6261, 64'h0, 5'd2, 64'h3231, 64'h0, 5'd2);
      send_stream('{8'h62, 8'h63}, 1'b1);
      wait_idle();
   endtask

   task automatic test_pattern_changed_mid_stream();
      load_regs(64'h72_7170, 64'h0, 5'd3, 64'h21, 64'h0, 5'd1);
      send_stream('{8'h70, 8'h71}, 1'b0);
      wait_idle();
      load_regs(64'h73_7271, 64'h0, 5'd3, 64'h21, 64'h0, 5'd1);
      send_stream('{8'h72, 8'h73, 8'h7F}, 1'b1);
      wait_idle();
   endtask

   // streams built mostly from pattern copies, some cut short or corrupted
   task automatic test_random_traffic();
      logic [LEN_W-1:0] plen_list[10] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2,
                                          5'd3, 5'd8, 5'd9, 5'd5, 5'd12};
      logic [LEN_W-1:0] rlen_list[10] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd4,
                                          5'd1, 5'd12, 5'd2, 5'd7, 5'd3};
      byte_vec_type     pat;
      byte_vec_type     rep;
      logic [7:0]       s[$];
      int               pl;
      int               target;
      int               start;
      int               cut;
      int               r;
      for (int p = 0; p < 10; p++) begin
         pl = span(plen_list[p]);
         for (int i = 0; i < WIN_DEPTH; i++) begin
            pat[i] = (i < pl) ? pick_sym() : 8'($urandom);
            rep[i] = 8'($urandom);
         end
         load_regs(pat[7:0], pat[15:8], plen_list[p], rep[7:0], rep[15:8], rlen_list[p]);
         calm <= (p == 5);
         start = items_sent;
         while (items_sent - start < 24) begin
            s.delete();
            target = ($urandom_range(9) == 0) ? 1 : $urandom_range(2 * pl + 8, 1);
            while (s.size() < target) begin
               r = $urandom_range(99);
               if (r < 55) begin
                  cut = ($urandom_range(4) == 0) ? $urandom_range(pl) : pl;
                  for (int i = 0; i < cut; i++) s.push_back(pat[i]);
                  if ($urandom_range(4) == 0 && s.size() > 0) s[$] = pick_sym();
               end else if (r < 85) begin
                  s.push_back(pick_sym());
               end else begin
                  s.push_back(8'($urandom));
               end
            end
            send_stream(s, 1'b1);
         end
         wait_idle();
      end
      calm <= 1'b0;
   endtask

   // every match yields 16 bytes while the result side holds off
   task automatic test_backpressure_fill();
      logic [7:0] s[$];
      load_regs(64'h41, 64'h0, 5'd1, {$urandom, $urandom}, {$urandom, $urandom}, 5'd16);
      hold_reqs <= hold_reqs + 1;
      repeat (6) begin
         s.delete();
         repeat (10) s.push_back(($urandom_range(3) == 0) ? 8'($urandom) : 8'h41);
         send_stream(s, 1'b1);
      end
      wait_idle();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_length_clamps();
      test_leftmost_no_overlap();
      test_pattern_shrunk_mid_stream();
      test_pattern_changed_mid_stream();
      test_random_traffic();
      test_backpressure_fill();
      wait_idle();
      if (fail_count == 0) begin
         $display("stream_find_replace verification clean");
      end else begin
         $display("stream_find_replace verification failed");
      end
      $finish;
   end

endmodule

[filelist.f]
design/sfr_pkg.sv
design/sfr_csr.sv
design/sfr_step.sv
design/sfr_burst.sv
design/stream_find_replace.sv
design/sfr_checker.sv
tb/sv/tb_stream_find_replace.sv
